// File: design/plist_pkg.sv
// Shared types, operation and status codes, and defaults for the positional list engine.
package plist_pkg;

  localparam int DEF_CAPACITY = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } out_word_t;

  typedef struct packed {
    logic full;
    logic ins_pos_ok;
    logic acc_pos_ok;
  } dp_flags_t;

  typedef struct packed {
    logic       load;
    logic       do_insert;
    logic       do_delete;
    logic       do_clear;
    logic       rd_ok;
    logic [1:0] status;
  } dp_cmd_t;

endpackage

// File: design/plist_ctrl.sv
// Controller: handshake state machine and operation decode for the positional list engine.
module plist_ctrl
  import plist_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [1:0] func,
  input  dp_flags_t flags,
  output logic      out_valid,
  input  logic      out_stall,
  output dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_HELD  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall  = (state == S_HELD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == S_HELD);

  always_comb begin
    state_next = state;
    case (state)
      S_EMPTY: begin
        if (accept) state_next = S_HELD;
      end
      S_HELD: begin
        if (!accept && !out_stall) state_next = S_EMPTY;
      end
      default: state_next = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = STATUS_OK;
    case (func)
      FUNC_INSERT: begin
        if (flags.full) begin
          cmd.status = STATUS_FULL;
        end else if (!flags.ins_pos_ok) begin
          cmd.status = STATUS_BADPOS;
        end else begin
          cmd.do_insert = accept;
        end
      end
      FUNC_READ: begin
        if (!flags.acc_pos_ok) begin
          cmd.status = STATUS_BADPOS;
        end else begin
          cmd.rd_ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (!flags.acc_pos_ok) begin
          cmd.status = STATUS_BADPOS;
        end else begin
          cmd.do_delete = accept;
        end
      end
      FUNC_CLEAR: begin
        cmd.do_clear = accept;
      end
      default: cmd.status = STATUS_OK;
    endcase
  end

endmodule

// File: design/plist_datapath.sv
// Datapath: entry registers with parallel shift, entry count, and result register.
module plist_datapath
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  output dp_flags_t flags,
  output out_word_t out_word
);

  logic signed [31:0] entries [CAPACITY];
  logic signed [31:0] entries_next [CAPACITY];
  logic [4:0]         count;
  logic [4:0]         count_next;
  logic [4:0]         pos_m1;
  logic signed [31:0] rd_data;

  assign pos_m1 = in_word.position - 5'd1;

  assign flags.full       = (count >= 5'(CAPACITY));
  assign flags.ins_pos_ok = (in_word.position != 5'd0) &&
                            ({1'b0, in_word.position} <= ({1'b0, count} + 6'd1));
  assign flags.acc_pos_ok = (in_word.position != 5'd0) && (in_word.position <= count);

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (5'(k) == pos_m1) rd_data = entries[k];
    end
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      entries_next[k] = entries[k];
    end
    if (cmd.do_insert) begin
      if (pos_m1 == 5'd0) entries_next[0] = in_word.value;
      for (int k = 1; k < CAPACITY; k++) begin
        if (5'(k) == pos_m1) begin
          entries_next[k] = in_word.value;
        end else if (5'(k) > pos_m1) begin
          entries_next[k] = entries[k-1];
        end
      end
    end else if (cmd.do_delete) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (5'(k) >= pos_m1) entries_next[k] = entries[k+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.do_clear) begin
      count_next = 5'd0;
    end else if (cmd.do_insert) begin
      count_next = count + 5'd1;
    end else if (cmd.do_delete) begin
      count_next = count - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      entries[k] <= entries_next[k];
    end
    if (cmd.load) begin
      out_word.status      <= cmd.status;
      out_word.read_value  <= cmd.rd_ok ? rd_data : 32'sd0;
      out_word.entry_count <= count_next;
    end
  end

endmodule

// File: design/positional_list_engine_unit.sv
// Top level of the positional list engine: controller and datapath.
// A result word appears in the cycle after its input word is accepted.
// One word per cycle unless output stalls; insert and delete shift entries in parallel.
// The result register frees in the cycle its word is taken, so input is stalled
// only while a result waits under output stall.
// Reset empties the list and drops any held result; entry and result contents stay unknown.
module positional_list_engine_unit
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (in_word.func),
    .flags     (flags),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  plist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .flags    (flags),
    .out_word (out_word)
  );

endmodule

// File: design/plist_checker.sv
// Port-level checker for the positional list engine and its bind to the top level.
module plist_checker
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word gave no result");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != STATUS_OK |-> out_word.read_value == 32'sd0)
    else $error("failed operation returned a nonzero read value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == STATUS_FULL |-> out_word.entry_count == 5'(CAPACITY))
    else $error("full status with a count below capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.entry_count <= 5'(CAPACITY))
    else $error("entry count above capacity");

endmodule

bind positional_list_engine_unit plist_checker #(.CAPACITY(CAPACITY)) u_plist_checker (.*);
